@@ hdl/cfq_pkg.sv @@
package cfq_pkg;

  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [1:0] REG_CAPACITY = 2'd0;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
    logic               is_empty;
    logic               is_full;
  } out_item_t;

endpackage

@@ hdl/cfq_ram.sv @@
module cfq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hdl/circular_fifo_queue.sv @@
// A result is registered in the s1 stage and then in the output register.
// Throughput: one transaction per cycle unless stalled; each transaction updates
// the pointers at most once and does at most one slot write, and the head and tail
// slots are read from two mirrored single-port-read RAMs with registered outputs.
// Reset: pointers go to slot 0, the queue is empty and capacity returns to 16.
// The slot memory is not cleared; slots are read only after they are written.
module circular_fifo_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,

  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cfq_pkg::in_item_t  in_data_i,

  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cfq_pkg::out_item_t out_data_o
);

  import cfq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = ($clog2(DEPTH + 1) > CAP_W) ? $clog2(DEPTH + 1) : CAP_W;

  logic [CAP_W-1:0]      cap_q;
  logic [CW-1:0]         eff_cap;

  logic [AW-1:0]         head_q, head_d;
  logic [AW-1:0]         tail_q, tail_d;
  logic                  empty_q, empty_d;

  logic                  in_accept;
  logic                  out_load;
  logic                  ok;
  logic                  wr_en;
  logic                  full_now;
  logic [DATA_WIDTH-1:0] wr_data;

  logic                  s1_valid_q;
  logic                  s1_ok_q;
  logic                  s1_empty_q;
  logic                  s1_full_q;
  logic                  s1_fwd_head_q;
  logic                  s1_fwd_tail_q;
  logic [DATA_WIDTH-1:0] s1_fwd_data_q;

  logic [DATA_WIDTH-1:0] rd_head;
  logic [DATA_WIDTH-1:0] rd_tail;

  logic                  out_valid_q;
  out_item_t             out_q;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [CW-1:0] cap);
    logic [CW-1:0] n;
    n = CW'(p) + CW'(1);
    adv = (n >= cap) ? '0 : AW'(n);
  endfunction

  assign pready = 1'b1;
  assign prdata = (paddr == REG_CAPACITY) ? 32'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr == REG_CAPACITY) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (CW'(cap_q) > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap_q);
    end
  end

  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign wr_data    = DATA_WIDTH'($unsigned(in_data_i.value));
  assign full_now   = !empty_q && adv(tail_q, eff_cap) == head_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    ok      = 1'b1;
    wr_en   = 1'b0;
    case (in_data_i.operation)
      OP_ENQUEUE: begin
        if (full_now) begin
          ok = 1'b0;
        end else begin
          wr_en   = 1'b1;
          empty_d = 1'b0;
          if (empty_q) begin
            head_d = '0;
            tail_d = '0;
          end else begin
            tail_d = adv(tail_q, eff_cap);
          end
        end
      end
      OP_DEQUEUE: begin
        if (empty_q) begin
          ok = 1'b0;
        end else if (head_q == tail_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b1;
        end else begin
          head_d = adv(head_q, eff_cap);
        end
      end
      default: begin
        ok = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      empty_q    <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        empty_q <= empty_d;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (out_load) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_ok_q       <= ok;
      s1_empty_q    <= empty_d;
      s1_full_q     <= !empty_d && adv(tail_d, eff_cap) == head_d;
      s1_fwd_head_q <= wr_en && head_d == tail_d;
      s1_fwd_tail_q <= wr_en;
      s1_fwd_data_q <= wr_data;
    end
  end

  cfq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept && wr_en),
    .waddr_i (tail_d),
    .wdata_i (wr_data),
    .re_i    (in_accept),
    .raddr_i (head_d),
    .rdata_o (rd_head)
  );

  cfq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept && wr_en),
    .waddr_i (tail_d),
    .wdata_i (wr_data),
    .re_i    (in_accept),
    .raddr_i (tail_d),
    .rdata_o (rd_tail)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_q.accepted <= s1_ok_q;
      out_q.is_empty <= s1_empty_q;
      out_q.is_full  <= s1_full_q;
      if (s1_empty_q) begin
        out_q.head_value <= '1;
        out_q.tail_value <= '1;
      end else begin
        out_q.head_value <= s1_fwd_head_q ? 32'(s1_fwd_data_q) : 32'(rd_head);
        out_q.tail_value <= s1_fwd_tail_q ? 32'(s1_fwd_data_q) : 32'(rd_tail);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0 && tail_q == '0))
    else $error("Empty queue with pointers away from slot 0.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_load |=> s1_valid_q && $stable(s1_ok_q) && $stable(s1_empty_q))
    else $error("Pending transaction lost while the output was stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_empty |->
      (out_q.head_value == -32'sd1 && out_q.tail_value == -32'sd1 && !out_q.is_full))
    else $error("Empty result carries data or a full status.");

endmodule

@@ verif/tb_circular_fifo_queue.sv @@
`timescale 1ns / 1ps

module tb_circular_fifo_queue;
  import cfq_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] CAP_ADDR = 2'(4 * REG_CAPACITY);
  localparam int HOLD_CYCLES = 90;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 30;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int full_stall_cycles = 0;
  int settings_written = 0;

  class queue_scoreboard;
    out_item_t        expected_status[$];
    logic [31:0]      slots[SLOTS];
    int unsigned      head_idx;
    int unsigned      tail_idx;
    bit               empty;
    logic [CAP_W-1:0] capacity;
    int               errors;
    int               checked;
    int               refused;

    function new();
      foreach (slots[i]) slots[i] = '0;
      head_idx = 0;
      tail_idx = 0;
      empty = 1'b1;
      capacity = CAP_RESET;
      errors = 0;
      checked = 0;
      refused = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int unsigned slots_in_use();
      if (capacity == 0) return 1;
      if (capacity > SLOTS) return SLOTS;
      return capacity;
    endfunction

    function int unsigned next_slot(int unsigned p);
      int unsigned n;
      n = p + 1;
      if (n >= slots_in_use()) n = 0;
      return n;
    endfunction

    function bit queue_full();
      return !empty && next_slot(tail_idx) == head_idx;
    endfunction

    function void note_transaction(in_item_t t);
      out_item_t   s;
      bit          ok;
      int unsigned p;
      ok = 1'b1;
      case (t.operation)
        OP_ENQUEUE: begin
          if (queue_full()) begin
            ok = 1'b0;
          end else begin
            p = empty ? 0 : next_slot(tail_idx);
            if (empty) head_idx = 0;
            tail_idx = p;
            slots[p] = t.value;
            empty = 1'b0;
          end
        end
        OP_DEQUEUE: begin
          if (empty) begin
            ok = 1'b0;
          end else if (head_idx == tail_idx) begin
            head_idx = 0;
            tail_idx = 0;
            empty = 1'b1;
          end else begin
            head_idx = next_slot(head_idx);
          end
        end
        default: ;
      endcase
      if (!ok) refused++;
      s.accepted = ok;
      s.head_value = empty ? '1 : slots[head_idx];
      s.tail_value = empty ? '1 : slots[tail_idx];
      s.is_empty = empty;
      s.is_full = queue_full();
      expected_status.push_back(s);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
    endtask

    task check_status(out_item_t got);
      out_item_t want;
      if (expected_status.size() == 0) begin
        report_mismatch("result with no pending transaction", got.head_value, '1);
      end else begin
        want = expected_status.pop_front();
        checked++;
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
        if (got.head_value !== want.head_value)
          report_mismatch("head_value", got.head_value, want.head_value);
        if (got.tail_value !== want.tail_value)
          report_mismatch("tail_value", got.tail_value, want.tail_value);
        if (got.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
        if (got.is_full !== want.is_full)
          report_mismatch("is_full", 32'(got.is_full), 32'(want.is_full));
      end
    endtask
  endclass

  queue_scoreboard sb;

  circular_fifo_queue u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_transaction(in_data);
      if (out_valid && !out_stall) sb.check_status(out_data);
      if (in_valid && in_stall) full_stall_cycles++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("circular_fifo_queue regression: fail");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [31:0] value);
    in_item_t t;
    t.operation = op;
    t.value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    @(posedge clk);
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= 32'(c);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_capacity(c);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(c)) sb.report_mismatch("capacity readback", prdata, 32'(c));
    psel <= 1'b0;
    penable <= 1'b0;
    settings_written++;
  endtask

  task automatic run_phase(logic [CAP_W-1:0] cap, int idle, int stall, int count,
                           bit hold_off);
    int          left;
    int          burst;
    int          enq_pct;
    int          r;
    logic [1:0]  op;
    logic [31:0] value;
    write_capacity(cap);
    send_idle_pct = idle;
    stall_pct = stall;
    if (hold_off) hold_requests++;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(40, 8);
      case ($urandom_range(2))
        0: enq_pct = 80;
        1: enq_pct = 50;
        default: enq_pct = 20;
      endcase
      while (burst > 0 && left > 0) begin
        r = $urandom_range(99);
        if (r < enq_pct) op = OP_ENQUEUE;
        else if (r < 92) op = OP_DEQUEUE;
        else op = $urandom_range(1) ? OP_QUERY : OP_UNUSED;
        case ($urandom_range(15))
          0: value = 32'h8000_0000;
          1: value = 32'h7fff_ffff;
          2: value = 32'hffff_ffff;
          3: value = 32'h0000_0000;
          default: value = $urandom;
        endcase
        send_item(op, value);
        burst--;
        left--;
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_QUERY, $urandom);
    send_item(OP_DEQUEUE, $urandom);
    send_item(OP_UNUSED, $urandom);
    send_item(OP_ENQUEUE, 32'h8000_0000);
    send_item(OP_ENQUEUE, 32'h7fff_ffff);
    send_item(OP_ENQUEUE, 32'hffff_ffff);
    send_item(OP_ENQUEUE, 32'h0000_0000);
    send_item(OP_ENQUEUE, 32'haaaa_aaaa);
    send_item(OP_ENQUEUE, 32'h5555_5555);
    repeat (10) send_item(OP_ENQUEUE, $urandom);
    send_item(OP_ENQUEUE, $urandom);
    send_item(OP_QUERY, $urandom);
    repeat (3) send_item(OP_DEQUEUE, $urandom);
    in_valid <= 1'b0;

    run_phase(5'd0, 0, 0, 60, 1'b0);
    run_phase(5'd31, 0, 0, 150, 1'b0);
    run_phase(5'd1, 63, 0, 100, 1'b0);
    run_phase(5'd5, 0, 63, 150, 1'b0);
    run_phase(5'd16, 10, 10, 150, 1'b0);
    run_phase(CAP_W'($urandom_range(15, 2)), 63, 0, 100, 1'b0);
    run_phase(5'd16, 0, 0, 80, 1'b1);
    run_phase(CAP_W'($urandom_range(15, 2)), 10, 10, 140, 1'b0);

    @(posedge clk);
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d transactions over %0d capacity settings, %0d of them refused.",
             sb.checked, settings_written, sb.refused);
    $display("Input was held back for %0d cycles while the output side stalled.",
             full_stall_cycles);
    if (sb.errors == 0) begin
      $display("circular_fifo_queue regression: pass");
    end else begin
      $display("circular_fifo_queue regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/cfq_pkg.sv
hdl/cfq_ram.sv
hdl/circular_fifo_queue.sv
verif/tb_circular_fifo_queue.sv
